>>> rtl/b64e_pkg.sv
// Shared types, constants and the sextet-to-ASCII mapping for the base64 encoder.
// No dependencies.
package b64e_pkg;

    localparam int unsigned CodeWidth = 8;
    localparam int unsigned SextetWidth = 6;
    localparam int unsigned BufDepth = 3;

    localparam logic [CodeWidth-1:0] SPACE_CODE = 8'h20;

    // One result word waiting to go out
    typedef struct packed {
        logic [CodeWidth-1:0] char_code;
        logic                 last_char;
    } res_t;

    // Head of the result buffer, offered to the output stage
    typedef struct packed {
        logic valid;
        res_t res;
    } head_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [CodeWidth-1:0] sextet_char(input logic [SextetWidth-1:0] v);
        logic [CodeWidth-1:0] code;
        begin
            if (v < 6'd26)
                code = 8'h41 + {2'b00, v};
            else if (v < 6'd52)
                code = 8'h61 + {2'b00, v - 6'd26};
            else if (v < 6'd62)
                code = 8'h30 + {2'b00, v - 6'd52};
            else if (v == 6'd62)
                code = 8'h2B;
            else
                code = 8'h2F;
            return code;
        end
    endfunction

endpackage

>>> rtl/b64e_if.sv
// Valid/ready stream interfaces for the byte input and the character output.
// Depends on nothing.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/b64e_pack.sv
// Encoder core: takes one byte word, forms up to three result words in one pass
// and holds them in a small result buffer. Depends on b64e_pkg.
module b64e_pack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_data,
    input  logic                 in_last,
    input  logic                 pop,
    output b64e_pkg::head_t      head
);
    import b64e_pkg::*;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } pos_t;

    logic       sep_en_reg;
    logic [3:0] left_reg, left_next;
    pos_t       pos_reg, pos_next;
    logic       parity_reg, parity_next;
    logic       first_done_reg, first_done_next;

    res_t       buf_reg [BufDepth];
    res_t       buf_next [BufDepth];
    logic [1:0] cnt_reg, cnt_next;

    res_t       new_res [BufDepth];
    logic [1:0] new_cnt;
    logic       accept;
    logic       sep;

    assign in_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign accept   = in_valid && in_ready;

    assign head.valid = (cnt_reg != 2'd0);
    assign head.res   = buf_reg[0];

    // Sextet formation and state update for the incoming byte
    always_comb
    begin
        new_res[0]      = '0;
        new_res[1]      = '0;
        new_res[2]      = '0;
        new_cnt         = 2'd0;
        left_next       = left_reg;
        pos_next        = pos_reg;
        parity_next     = parity_reg;
        first_done_next = first_done_reg;
        sep             = sep_en_reg && first_done_reg && !parity_reg;
        case (pos_reg)
            POS_SECOND:
            begin
                new_res[0] = '{sextet_char({left_reg[1:0], in_data[7:4]}), 1'b0};
                new_res[1] = '{sextet_char({in_data[3:0], 2'b00}), 1'b1};
                new_cnt    = in_last ? 2'd2 : 2'd1;
                left_next  = in_data[3:0];
                pos_next   = POS_THIRD;
            end
            POS_THIRD:
            begin
                new_res[0]      = '{sextet_char({left_reg, in_data[7:6]}), 1'b0};
                new_res[1]      = '{sextet_char(in_data[5:0]), in_last};
                new_cnt         = 2'd2;
                left_next       = 4'd0;
                pos_next        = POS_FIRST;
                parity_next     = !parity_reg;
                first_done_next = 1'b1;
            end
            default:
            begin
                // first byte of a group, with an optional leading space
                if (sep)
                begin
                    new_res[0] = '{SPACE_CODE, 1'b0};
                    new_res[1] = '{sextet_char(in_data[7:2]), 1'b0};
                    new_res[2] = '{sextet_char({in_data[1:0], 4'b0000}), 1'b1};
                    new_cnt    = in_last ? 2'd3 : 2'd2;
                end
                else
                begin
                    new_res[0] = '{sextet_char(in_data[7:2]), 1'b0};
                    new_res[1] = '{sextet_char({in_data[1:0], 4'b0000}), 1'b1};
                    new_cnt    = in_last ? 2'd2 : 2'd1;
                end
                left_next = {2'b00, in_data[1:0]};
                pos_next  = POS_SECOND;
            end
        endcase
        // end of message: back to the start of a fresh stream
        if (in_last)
        begin
            left_next       = 4'd0;
            pos_next        = POS_FIRST;
            parity_next     = 1'b0;
            first_done_next = 1'b0;
        end
    end

    // Result buffer: load on accept, otherwise shift down on pop
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            buf_next = new_res;
            cnt_next = new_cnt;
        end
        else if (pop)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    // Control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_en_reg     <= 1'b1;
            left_reg       <= 4'd0;
            pos_reg        <= POS_FIRST;
            parity_reg     <= 1'b0;
            first_done_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                sep_en_reg <= cfg_wdata;
            if (accept)
            begin
                left_reg       <= left_next;
                pos_reg        <= pos_next;
                parity_reg     <= parity_next;
                first_done_reg <= first_done_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Buffer payload
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

>>> rtl/b64e_drain.sv
// Output register stage: moves one result word a cycle from the buffer head onto the
// character stream while out_ready does not stall it. Depends on b64e_pkg.
module b64e_drain (
    input  logic            clk,
    input  logic            rst_n,
    input  b64e_pkg::head_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_char,
    output logic            out_last
);
    import b64e_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       last_reg;

    // Take the head whenever the output register is empty or being emptied
    assign pop        = head.valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            char_reg <= head.res.char_code;
            last_reg <= head.res.last_char;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/base64_byte_stream_encoder.sv
// Base64 byte stream encoder, no padding. Characters go from the result buffer through the
// output register to the output port. Throughput: one character a cycle there unless it
// stalls; a byte (1, 2 or 3 characters) is taken only when the buffer is empty or its last
// character is popped. rst_n clears the stream state and sets separator_enable to 1.
// Depends on b64e_pkg, b64e_if, b64e_pack, b64e_drain.
module base64_byte_stream_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    b64e_byte_if.sink          bytes,
    b64e_char_if.source        chars
);
    import b64e_pkg::*;

    head_t head;
    logic  pop;

    // Encoder core with result buffer
    b64e_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (bytes.valid),
        .in_ready  (bytes.ready),
        .in_data   (bytes.data_byte),
        .in_last   (bytes.last_byte),
        .pop       (pop),
        .head      (head)
    );

    // Output register
    b64e_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (chars.valid),
        .out_ready (chars.ready),
        .out_char  (chars.char_code),
        .out_last  (chars.last_char)
    );

endmodule

>>> rtl/b64e_checker.sv
// Port-level checks on the character stream of the encoder, bound to the top level.
// Depends on base64_byte_stream_encoder.
module b64e_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    // A stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
        else $error("output word changed while stalled");

    // Only alphabet characters or the space leave the block
    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_char >= 8'h41 && out_char <= 8'h5A) ||
                       (out_char >= 8'h61 && out_char <= 8'h7A) ||
                       (out_char >= 8'h30 && out_char <= 8'h39) ||
                       out_char == 8'h2B || out_char == 8'h2F || out_char == 8'h20))
        else $error("illegal character code");

    // A separator is never the end of a message
    a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == 8'h20 |-> !out_last)
        else $error("space marked as final character");

    // A space is never followed directly by another space
    a_no_double_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_char == 8'h20 ##1 out_valid |-> out_char != 8'h20)
        else $error("two separators in a row");

endmodule

bind base64_byte_stream_encoder b64e_checker u_b64e_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.char_code),
    .out_last  (chars.last_char)
);

>>> bench/tb_base64_byte_stream_encoder.sv
`timescale 1ns / 100ps
// Self-checking bench for base64_byte_stream_encoder: byte words in, base64 characters out.
// Depends on b64e_pkg, b64e_if (b64e_byte_if, b64e_char_if) and the encoder RTL.
module tb_base64_byte_stream_encoder;

    import b64e_pkg::*;

    // Cycles with no word accepted on either side before the run is abandoned.
    // Worst legal lull is the deliberate receiver hold (HOLD_CYCLES) or a long
    // random stall at 81 % idling, far below this.
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 100;

    // Standard alphabet, first character in the top byte
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    b64e_byte_if byte_bus ();
    b64e_char_if char_bus ();

    base64_byte_stream_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bytes     (byte_bus),
        .chars     (char_bus)
    );

    // Encoder shadow state
    logic       sep_enable_shadow;
    logic [3:0] enc_carry;
    logic [1:0] enc_slot;
    logic       enc_parity;
    logic       enc_first_done;

    res_t expected_chars [$];

    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned ready_hold_left = 0;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_ALPHABET[8*(63 - int'(v)) +: 8];
    endfunction

    function automatic void push_char(input logic [7:0] code, input logic lst);
        res_t r;
        r.char_code = code;
        r.last_char = lst;
        expected_chars.push_back(r);
    endfunction

    function automatic void clear_encoder_state();
        enc_carry      = 4'd0;
        enc_slot       = 2'd0;
        enc_parity     = 1'b0;
        enc_first_done = 1'b0;
    endfunction

    // Expected characters for one accepted byte word
    function automatic void encode_byte(input logic [7:0] d, input logic lst);
        case (enc_slot)
            2'd1:
            begin
                push_char(b64_char({enc_carry[1:0], d[7:4]}), 1'b0);
                if (lst)
                    push_char(b64_char({d[3:0], 2'b00}), 1'b1);
                else
                begin
                    enc_carry = d[3:0];
                    enc_slot  = 2'd2;
                end
            end
            2'd2:
            begin
                push_char(b64_char({enc_carry, d[7:6]}), 1'b0);
                push_char(b64_char(d[5:0]), lst);
                enc_carry      = 4'd0;
                enc_slot       = 2'd0;
                enc_parity     = ~enc_parity;
                enc_first_done = 1'b1;
            end
            default:
            begin
                // space ahead of every second group after the first
                if (sep_enable_shadow && enc_first_done && !enc_parity)
                    push_char(SPACE_CODE, 1'b0);
                push_char(b64_char(d[7:2]), 1'b0);
                if (lst)
                    push_char(b64_char({d[1:0], 4'b0000}), 1'b1);
                else
                begin
                    enc_carry = {2'b00, d[1:0]};
                    enc_slot  = 2'd1;
                end
            end
        endcase
        if (lst)
            clear_encoder_state();
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Receiver: random stalls, plus a long hold when one is requested
    initial
    begin
        char_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold_left > 0)
            begin
                char_bus.ready <= 1'b0;
                ready_hold_left--;
            end
            else
                char_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && char_bus.valid && char_bus.ready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("unexpected char_code", char_bus.char_code, 8'h00);
            else
            begin
                want = expected_chars.pop_front();
                if (char_bus.char_code !== want.char_code)
                    report_mismatch("char_code", char_bus.char_code, want.char_code);
                if (char_bus.last_char !== want.last_char)
                    report_mismatch("last_char", {7'd0, char_bus.last_char},
                                    {7'd0, want.last_char});
            end
        end
    end

    // Watchdog on words moving through either port
    always @(posedge clk)
    begin
        if ((byte_bus.valid && byte_bus.ready) || (char_bus.valid && char_bus.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one byte word from a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] d, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_bus.valid <= 1'b0;
            @(negedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= d;
        byte_bus.last_byte <= lst;
        do
            @(posedge clk);
        while (!byte_bus.ready);
        encode_byte(d, lst);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_separator(input logic en);
        wait_drained();
        cfg_wdata <= en;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sep_enable_shadow = en;
        @(negedge clk);
    endtask

    // Short messages of one, two and three bytes, then a seven-byte one that earns a space
    task automatic test_directed_extremes();
        logic [7:0] seven [0:6];
        seven = '{8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01};
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b1);
        for (int i = 0; i < 7; i++)
            send_byte(seven[i], i == 6);
    endtask

    // Separator switched off, then back on, part way through one message
    task automatic test_enable_mid_message();
        set_separator(1'b0);
        for (int i = 0; i < 7; i++)
            send_byte(8'(i * 37 + 3), 1'b0);
        set_separator(1'b1);
        for (int i = 7; i < 13; i++)
            send_byte(8'(i * 59 + 11), i == 12);
    endtask

    // Random messages under one idling profile, with occasional register changes
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                       input int n_words);
        int sent;
        int msg_len;
        logic [7:0] d;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(0, 9) == 0)
                set_separator(1'($urandom_range(0, 1)));
            msg_len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(13, 30))
                                                  : int'($urandom_range(1, 12));
            for (int i = 0; i < msg_len && sent < n_words; i++)
            begin
                case ($urandom_range(0, 7))
                    0: d = 8'h00;
                    1: d = 8'hFF;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                send_byte(d, i == msg_len - 1);
                sent++;
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        wait_drained();
        ready_hold_left = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_byte(8'($urandom_range(0, 255)), i == 23);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = 8'h00;
        byte_bus.last_byte = 1'b0;
        sep_enable_shadow  = 1'b1;
        clear_encoder_state();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_enable_mid_message();
        test_random_traffic(26, 81, 56);
        test_random_traffic(81, 26, 56);
        test_random_traffic(0, 0, 56);
        test_output_backpressure();

        // Let the last characters out, then allow for the pipeline
        byte_bus.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_pack.sv
rtl/b64e_drain.sv
rtl/base64_byte_stream_encoder.sv
rtl/b64e_checker.sv
bench/tb_base64_byte_stream_encoder.sv
